FILE: rtl/ecc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ecc_pkg;

    // Number of floors served by the car. Floor indexes and call masks are
    // carried in fixed 3-bit and 5-bit fields.
    localparam int FLOORS   = 5;
    localparam int FLOOR_W  = 3;
    localparam int CALL_W   = 5;
    localparam int DELAY_W  = 12;
    localparam int COUNT_W  = 16;

    localparam logic [CALL_W-1:0] FLOOR_MASK = CALL_W'((1 << FLOORS) - 1);

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(10);

    // Mode codes as seen on the result word.
    localparam logic [2:0] MODE_MOVING   = 3'd0;
    localparam logic [2:0] MODE_ARRIVING = 3'd1;
    localparam logic [2:0] MODE_STOPPING = 3'd2;
    localparam logic [2:0] MODE_OPENING  = 3'd3;
    localparam logic [2:0] MODE_WAITING  = 3'd4;
    localparam logic [2:0] MODE_CLOSING  = 3'd5;

    // Travel direction codes.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // Car state machine, one-hot.
    typedef enum logic [5:0] {
        S_MOVING   = 6'b000001,
        S_ARRIVING = 6'b000010,
        S_STOPPING = 6'b000100,
        S_OPENING  = 6'b001000,
        S_WAITING  = 6'b010000,
        S_CLOSING  = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [FLOOR_W-1:0] floor_position;
        logic [CALL_W-1:0]  new_calls;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         mode;
        logic [1:0]         travel_dir;
        logic [FLOOR_W-1:0] target;
        logic [CALL_W-1:0]  pending_mask;
    } t_out_word;

    // Complete controller state carried from one tick to the next.
    typedef struct packed {
        t_mode              mode;
        logic [1:0]         dir;
        logic [FLOOR_W-1:0] target;
        logic [COUNT_W-1:0] count;
        logic [CALL_W-1:0]  pending;
    } t_state;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] code;
        unique case (m)
            S_MOVING:   code = MODE_MOVING;
            S_ARRIVING: code = MODE_ARRIVING;
            S_STOPPING: code = MODE_STOPPING;
            S_OPENING:  code = MODE_OPENING;
            S_WAITING:  code = MODE_WAITING;
            S_CLOSING:  code = MODE_CLOSING;
            default:    code = MODE_WAITING;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ecc_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Next-state logic for one control tick of the car.
module ecc_step import ecc_pkg::*; (
    input  t_state             i_state,
    input  t_in_word           i_word,
    input  logic [DELAY_W-1:0] i_phase_delay,
    output t_state             o_state
);

    logic [FLOOR_W-1:0] pos;
    logic [CALL_W-1:0]  pending;
    logic [CALL_W-1:0]  target_clr;
    logic [COUNT_W-1:0] delay_ext;
    logic [COUNT_W-1:0] wait_load;
    logic [COUNT_W-1:0] count_dec;
    logic               count_zero;
    logic               up_hit;
    logic               dn_hit;
    logic               near_hit;
    logic [FLOOR_W-1:0] up_floor;
    logic [FLOOR_W-1:0] dn_floor;
    logic [FLOOR_W-1:0] near_floor;
    logic [FLOOR_W-1:0] near_dist;
    logic [FLOOR_W-1:0] gap;

    assign pos        = i_word.floor_position;
    assign pending    = (i_state.pending | i_word.new_calls) & FLOOR_MASK;
    assign delay_ext  = COUNT_W'(i_phase_delay);
    // Twelve times the delay as two shifted copies.
    assign wait_load  = (delay_ext << 3) + (delay_ext << 2);
    assign count_zero = (i_state.count == '0);
    assign count_dec  = i_state.count - COUNT_W'(1);

    // Lowest pending floor strictly between the car and the target going up.
    always_comb begin
        up_hit   = 1'b0;
        up_floor = '0;
        for (int i = 0; i < FLOORS; i++) begin
            if (!up_hit && pending[i] && (FLOOR_W'(i) > pos)
                    && (FLOOR_W'(i) < i_state.target)) begin
                up_hit   = 1'b1;
                up_floor = FLOOR_W'(i);
            end
        end
    end

    // Highest pending floor strictly between the target and the car going down.
    always_comb begin
        dn_hit   = 1'b0;
        dn_floor = '0;
        for (int i = FLOORS - 1; i >= 0; i--) begin
            if (!dn_hit && pending[i] && (FLOOR_W'(i) < pos)
                    && (FLOOR_W'(i) > i_state.target)) begin
                dn_hit   = 1'b1;
                dn_floor = FLOOR_W'(i);
            end
        end
    end

    // Nearest pending floor; a tie keeps the lower floor found first.
    always_comb begin
        near_hit   = 1'b0;
        near_floor = '0;
        near_dist  = '0;
        gap        = '0;
        for (int i = 0; i < FLOORS; i++) begin
            gap = (pos > FLOOR_W'(i)) ? (pos - FLOOR_W'(i)) : (FLOOR_W'(i) - pos);
            if (pending[i] && (!near_hit || (gap < near_dist))) begin
                near_hit   = 1'b1;
                near_dist  = gap;
                near_floor = FLOOR_W'(i);
            end
        end
    end

    // Call bit of the current target, cleared on arrival.
    always_comb begin
        for (int i = 0; i < CALL_W; i++) begin
            target_clr[i] = (FLOOR_W'(i) == i_state.target);
        end
    end

    // Mode sequencing.
    always_comb begin
        o_state         = i_state;
        o_state.pending = pending;
        unique case (i_state.mode)
            S_MOVING: begin
                if (pos == i_state.target) begin
                    o_state.mode  = S_ARRIVING;
                    o_state.count = delay_ext;
                end else if ((i_state.dir == DIR_UP) && up_hit) begin
                    o_state.target = up_floor;
                end else if ((i_state.dir == DIR_DOWN) && dn_hit) begin
                    o_state.target = dn_floor;
                end
            end
            S_ARRIVING: begin
                if (!count_zero) begin
                    o_state.count = count_dec;
                end else begin
                    o_state.pending = pending & ~target_clr;
                    o_state.mode    = S_STOPPING;
                    o_state.dir     = DIR_NONE;
                    o_state.count   = delay_ext;
                end
            end
            S_STOPPING: begin
                if (!count_zero) begin
                    o_state.count = count_dec;
                end else begin
                    o_state.mode  = S_OPENING;
                    o_state.count = delay_ext;
                end
            end
            S_OPENING: begin
                if (!count_zero) begin
                    o_state.count = count_dec;
                end else begin
                    o_state.mode  = S_WAITING;
                    o_state.count = wait_load;
                end
            end
            S_WAITING: begin
                if (!count_zero) begin
                    o_state.count = count_dec;
                end else if (near_hit) begin
                    o_state.target = near_floor;
                    o_state.mode   = S_CLOSING;
                    o_state.count  = delay_ext;
                end
            end
            S_CLOSING: begin
                if (!count_zero) begin
                    o_state.count = count_dec;
                end else begin
                    o_state.dir  = (i_state.target < pos) ? DIR_DOWN : DIR_UP;
                    o_state.mode = S_MOVING;
                end
            end
            default: begin
                o_state.mode = i_state.mode;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/elevator_car_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Elevator car controller, advanced by one control tick per input word.
// Input channel (i_valid / o_ready / i_data): each word carries the sensed
// floor and a mask of new floor calls. Output channel (o_valid / i_ready /
// o_data): exactly one result word per input word, giving mode, direction,
// target floor and the pending-call mask after that tick.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
// phase delay; it is always ready and should be written only while idle.
// The result word is valid in the cycle after its input word is taken.
// Throughput: one word per cycle while the receiver is ready; the whole tick
// is a single pass of logic from the state registers to the result register.
// When the receiver stalls, the result register holds its word and the
// input channel accepts a new word only in a cycle where that word leaves.
// Reset (synchronous, active low) puts the car in waiting with zero count,
// no direction, target floor zero, no pending calls, and a phase delay of
// ten ticks; no result word is pending after reset.
module elevator_car_controller import ecc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_in_word           i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_out_word               o_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [DELAY_W-1:0] i_cfg_data
);

    t_state             r_state;
    t_state             n_state;
    t_out_word          r_out;
    logic               r_out_valid;
    logic [DELAY_W-1:0] r_phase_delay;
    logic               in_fire;

    assign o_ready     = !r_out_valid || i_ready;
    assign in_fire     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_delay <= DELAY_RESET;
        end else if (i_cfg_valid) begin
            r_phase_delay <= i_cfg_data;
        end
    end

    ecc_step u_step (
        .i_state       (r_state),
        .i_word        (i_data),
        .i_phase_delay (r_phase_delay),
        .o_state       (n_state)
    );

    // State update on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode    <= S_WAITING;
            r_state.dir     <= DIR_NONE;
            r_state.target  <= '0;
            r_state.count   <= '0;
            r_state.pending <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.mode         <= mode_code(n_state.mode);
            r_out.travel_dir   <= n_state.dir;
            r_out.target       <= n_state.target;
            r_out.pending_mask <= n_state.pending;
        end
    end

    // Every accepted word yields a result word in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_valid)
        else $error("result word missing after accepted input");

    // New calls stay latched unless the tick was an arrival, which clears one.
    a_calls_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_state.mode != S_ARRIVING)) |=>
        ((o_data.pending_mask & $past(i_data.new_calls & FLOOR_MASK))
            == $past(i_data.new_calls & FLOOR_MASK)))
        else $error("new call lost from pending mask");

    // Only a moving or arriving car has a travel direction.
    a_dir_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_data.mode == MODE_MOVING) || (o_data.mode == MODE_ARRIVING))
            == (o_data.travel_dir != DIR_NONE)))
        else $error("travel direction inconsistent with mode");

    // The target is always an existing floor.
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.target < FLOOR_W'(FLOORS)))
        else $error("target floor out of range");

endmodule

`default_nettype wire

FILE: test/tb_elevator_car_controller.sv
`timescale 1ns / 1ps

module tb_elevator_car_controller;
    import ecc_pkg::*;

    // Length of the forced receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 150;

    // Opening sequence of ticks, {floor_position, new_calls}, first word in the top byte.
    // It walks tie-breaking between two calls, an empty waiting check, a nearer
    // call while moving down, a sensed floor above the top, a call latched on
    // the clearing tick, and a close with the target at the current floor.
    localparam logic [25*8-1:0] OPENING_TICKS = {
        8'h40, 8'h40, 8'h51, 8'h40, 8'h42, 8'h22, 8'h22, 8'h20, 8'h20, 8'h20,
        8'h20, 8'hE0, 8'hC0, 8'h80, 8'h80, 8'h80, 8'h80, 8'hA4, 8'h40, 8'h40,
        8'h5F, 8'h40, 8'h00, 8'h68, 8'h60
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    t_in_word           in_word = '0;
    logic               status_valid;
    logic               out_ready = 1'b0;
    t_out_word          status_word;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [DELAY_W-1:0] cfg_data = '0;

    // Ticks waiting to be driven, and status words the car should report.
    t_in_word  tick_queue[$];
    t_out_word predicted_status[$];

    // Predicted car state and phase delay register.
    logic [2:0]         car_mode = MODE_WAITING;
    logic [1:0]         car_dir = DIR_NONE;
    logic [FLOOR_W-1:0] car_target = '0;
    logic [COUNT_W-1:0] car_count = '0;
    logic [CALL_W-1:0]  car_calls = '0;
    logic [DELAY_W-1:0] car_delay = DELAY_RESET;

    // Where the stimulus places the car in the shaft.
    int shaft_floor = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;

    int mismatches = 0;
    int ticks_sent = 0;
    int words_checked = 0;
    int stops = 0;
    int phases = 0;

    elevator_car_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_data      (in_word),
        .o_valid     (status_valid),
        .i_ready     (out_ready),
        .o_data      (status_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Prints one line per mismatch, up to a limit, and counts them all.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 30) begin
            $display("[%0t] status word %0d: %s is %0d, expected %0d",
                     $realtime, words_checked, what, got, want);
        end
        mismatches++;
    endtask

    function automatic bit call_at(input int f);
        return (f >= 0 && f < FLOORS) ? car_calls[f] : 1'b0;
    endfunction

    // Advances the predicted car by one tick and queues the status word it reports.
    task automatic advance_car(input t_in_word w);
        int        pos;
        int        f;
        int        hit;
        int        gap;
        int        best;
        int        best_dist;
        t_out_word word;
        pos = int'(w.floor_position);
        hit = -1;
        best = -1;
        best_dist = 0;
        car_calls = (car_calls | w.new_calls) & FLOOR_MASK;
        case (car_mode)
            MODE_MOVING: begin
                if (pos == int'(car_target)) begin
                    car_mode = MODE_ARRIVING;
                    car_count = COUNT_W'(car_delay);
                    stops++;
                end else if (car_dir == DIR_UP) begin
                    for (f = pos + 1; f < int'(car_target); f++) begin
                        if (hit < 0 && call_at(f)) hit = f;
                    end
                end else if (car_dir == DIR_DOWN) begin
                    for (f = pos; f > int'(car_target) + 1; f--) begin
                        if (hit < 0 && call_at(f - 1)) hit = f - 1;
                    end
                end
                if (hit >= 0) car_target = FLOOR_W'(hit);
            end
            MODE_ARRIVING: begin
                if (car_count != 0) begin
                    car_count--;
                end else begin
                    if (int'(car_target) < FLOORS) car_calls[car_target] = 1'b0;
                    car_mode = MODE_STOPPING;
                    car_dir = DIR_NONE;
                    car_count = COUNT_W'(car_delay);
                end
            end
            MODE_STOPPING: begin
                if (car_count != 0) begin
                    car_count--;
                end else begin
                    car_mode = MODE_OPENING;
                    car_count = COUNT_W'(car_delay);
                end
            end
            MODE_OPENING: begin
                if (car_count != 0) begin
                    car_count--;
                end else begin
                    car_mode = MODE_WAITING;
                    car_count = COUNT_W'(12 * int'(car_delay));
                end
            end
            MODE_WAITING: begin
                if (car_count != 0) begin
                    car_count--;
                end else begin
                    // Nearest pending floor wins; the scan runs upward, so ties go low.
                    for (f = 0; f < FLOORS; f++) begin
                        if (call_at(f)) begin
                            gap = (pos > f) ? pos - f : f - pos;
                            if (best < 0 || gap < best_dist) begin
                                best = f;
                                best_dist = gap;
                            end
                        end
                    end
                    if (best >= 0) begin
                        car_target = FLOOR_W'(best);
                        car_mode = MODE_CLOSING;
                        car_count = COUNT_W'(car_delay);
                    end
                end
            end
            MODE_CLOSING: begin
                if (car_count != 0) begin
                    car_count--;
                end else begin
                    car_dir = (int'(car_target) < pos) ? DIR_DOWN : DIR_UP;
                    car_mode = MODE_MOVING;
                end
            end
            default: begin
            end
        endcase
        word.mode = car_mode;
        word.travel_dir = car_dir;
        word.target = car_target;
        word.pending_mask = car_calls;
        predicted_status.push_back(word);
    endtask

    // Builds the next tick: the car mostly travels toward its target with
    // occasional calls, and a few ticks carry arbitrary sensor and call values.
    function automatic t_in_word next_tick();
        t_in_word w;
        int       r;
        r = $urandom_range(99);
        if (r < 6) begin
            w.floor_position = 3'($urandom);
            w.new_calls = 5'($urandom);
            return w;
        end
        if (car_mode == MODE_MOVING && $urandom_range(1) == 1) begin
            if (shaft_floor < int'(car_target)) shaft_floor++;
            else if (shaft_floor > int'(car_target)) shaft_floor--;
        end
        w.floor_position = 3'(shaft_floor);
        if (r < 20) w.new_calls = 5'(1 << $urandom_range(FLOORS - 1));
        else if (r < 26) w.new_calls = 5'($urandom);
        else w.new_calls = '0;
        return w;
    endfunction

    // Input driver: offers queued ticks, idling at random between words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_word <= tick_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: tracks register writes and accepted ticks, then checks each
    // delivered status word against the oldest prediction.
    always @(posedge i_clk) begin : watch_ports
        t_out_word want;
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready) car_delay = cfg_data;
            if (in_valid && in_ready) begin
                advance_car(in_word);
                ticks_sent++;
            end
            if (status_valid && out_ready) begin
                if (predicted_status.size() == 0) begin
                    report_mismatch("unexpected word", int'(status_word), 0);
                end else begin
                    want = predicted_status.pop_front();
                    if (status_word.mode != want.mode)
                        report_mismatch("mode", status_word.mode, want.mode);
                    if (status_word.travel_dir != want.travel_dir)
                        report_mismatch("travel_dir", status_word.travel_dir, want.travel_dir);
                    if (status_word.target != want.target)
                        report_mismatch("target", status_word.target, want.target);
                    if (status_word.pending_mask != want.pending_mask)
                        report_mismatch("pending_mask", status_word.pending_mask,
                                        want.pending_mask);
                end
                words_checked++;
            end
        end
    end

    // Waits until every tick is taken and every status word is back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || in_valid || predicted_status.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_phase_delay(input logic [DELAY_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic feed_ticks(input int n);
        repeat (n) begin
            do @(negedge i_clk);
            while (tick_queue.size() != 0);
            tick_queue.push_back(next_tick());
        end
    endtask

    task automatic start_phase(input logic [DELAY_W-1:0] value, input int send_pct,
                               input int stall_pct);
        wait_idle();
        write_phase_delay(value);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        phases++;
    endtask

    initial begin
        int i;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening with no delay so every phase turns over quickly.
        start_phase(12'd0, 0, 0);
        for (i = 24; i >= 0; i--) begin
            tick_queue.push_back(t_in_word'(OPENING_TICKS[8*i +: 8]));
        end

        start_phase(12'd0, 0, 0);
        feed_ticks(170);
        start_phase(12'd1, 48, 0);
        feed_ticks(170);

        // Receiver stalls, with one long hold-off so the input side backs up.
        start_phase(12'd10, 0, 48);
        feed_ticks(20);
        @(posedge i_clk);
        hold_reqs <= hold_reqs + 1;
        feed_ticks(150);

        start_phase(12'd2, 22, 22);
        feed_ticks(170);

        // Bring the doors to opening, then switch to the largest delay so the
        // waiting count loads twelve times the maximum.
        start_phase(12'd3, 22, 22);
        for (k = 0; k < 400 && car_mode != MODE_OPENING; k++) begin
            feed_ticks(1);
            wait_idle();
        end
        start_phase(12'd4095, 22, 22);
        feed_ticks(40);

        wait_idle();
        repeat (5) @(posedge i_clk);
        if (predicted_status.size() != 0)
            report_mismatch("words never delivered", 0, predicted_status.size());

        $display("Ran %0d car ticks in %0d phases; %0d status words checked, %0d floor stops.",
                 ticks_sent, phases, words_checked, stops);
        $display("Phase delays 0 to 4095, idle and stall mixes, and a long output hold-off.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ecc_pkg.sv
rtl/ecc_step.sv
rtl/elevator_car_controller.sv
test/tb_elevator_car_controller.sv
